>>> rtl/cfdo_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the circular FIFO with drop or overwrite.
// No dependencies.
package cfdo_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int ITEM_BITS_DEF = 32;
    localparam int CNT_W         = 9;
    localparam int CMD_W         = 3;
    localparam int IDX_W         = 8;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

    // Register select, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_MODE     = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH       = 3'd0,
        CMD_POP        = 3'd1,
        CMD_PEEK       = 3'd2,
        CMD_PEEK_INDEX = 3'd3,
        CMD_CLEAR      = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic             we;
        logic             re;
        t_status          status;
        logic [CNT_W-1:0] fill_count;
        logic             empty;
        logic             full;
    } t_step_info;

endpackage

>>> rtl/circular_fifo_drop_or_overwrite.sv
`timescale 1ns / 1ps
// Circular FIFO top level: APB registers, slot memory and result register.
// Depends on cfdo_pkg and cfdo_ctrl.
//
// Takes one command per clock unless a result beat is stalled (push, pop, peek
// oldest, peek at offset, clear) and returns one result beat for each in the
// next cycle; read data comes from the slot memory's registered read port, read
// and written in the same cycle the command is accepted. A push into a full
// FIFO is refused or overwrites the oldest entry, as the mode register selects.
// A capacity write empties the FIFO and clamps the capacity used to 1..DEPTH.
module circular_fifo_drop_or_overwrite
    import cfdo_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int ITEM_BITS = ITEM_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [ITEM_BITS-1:0] i_push_data,
    input  logic [IDX_W-1:0]     i_peek_index,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [ITEM_BITS-1:0] o_read_data,
    output logic [CNT_W-1:0]     o_fill_count,
    output logic                 o_empty_flag,
    output logic                 o_full_flag,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'((DEPTH > 511) ? 511 : DEPTH);
    localparam logic [CNT_W-1:0] CAP_RST_E = CNT_W'((DEPTH < 256) ? DEPTH : 256);

    logic [ITEM_BITS-1:0] r_mem [DEPTH];
    logic [ITEM_BITS-1:0] r_mem_q;
    logic [CNT_W-1:0]     r_cap_raw;
    logic [CNT_W-1:0]     r_cap;
    logic [CNT_W-1:0]     n_cap;
    logic                 r_mode;
    logic                 r_out_valid;
    logic                 r_rd_sel;
    t_status              r_status;
    logic [CNT_W-1:0]     r_fill_count;
    logic                 r_empty;
    logic                 r_full;

    logic                 acc;
    logic                 cfg_wr;
    logic                 cap_wr;
    logic [CNT_W-1:0]     wcap;
    logic [PTR_W-1:0]     waddr;
    logic [PTR_W-1:0]     raddr;
    t_step_info           info;

    assign pready     = 1'b1;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign acc        = i_in_valid && o_in_ready;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign cap_wr     = cfg_wr && (paddr[2] == REG_CAPACITY);
    assign wcap       = pwdata[CNT_W-1:0];

    always_comb begin
        if (wcap == '0) begin
            n_cap = CNT_W'(1);
        end else if (wcap > CAP_MAX) begin
            n_cap = CAP_MAX;
        end else begin
            n_cap = wcap;
        end
    end

    always_comb begin
        if (paddr[2] == REG_MODE) begin
            prdata = APB_DW'(r_mode);
        end else begin
            prdata = APB_DW'(r_cap_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_raw <= CAP_RESET;
            r_cap     <= CAP_RST_E;
            r_mode    <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MODE) begin
                r_mode <= pwdata[0];
            end else begin
                r_cap_raw <= wcap;
                r_cap     <= n_cap;
            end
        end
    end

    cfdo_ctrl #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (acc),
        .i_flush      (cap_wr),
        .i_command    (i_command),
        .i_peek_index (i_peek_index),
        .i_cap        (r_cap),
        .i_mode       (r_mode),
        .o_waddr      (waddr),
        .o_raddr      (raddr),
        .o_info       (info)
    );

    always_ff @(posedge i_clk) begin
        if (acc && info.we) begin
            r_mem[waddr] <= i_push_data;
        end
        if (acc && info.re) begin
            r_mem_q <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_sel     <= info.re;
            r_status     <= info.status;
            r_fill_count <= info.fill_count;
            r_empty      <= info.empty;
            r_full       <= info.full;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_data  = r_rd_sel ? r_mem_q : '0;
    assign o_fill_count = r_fill_count;
    assign o_empty_flag = r_empty;
    assign o_full_flag  = r_full;

endmodule

>>> rtl/cfdo_ctrl.sv
`timescale 1ns / 1ps
// Pointer and count control: decodes one command per beat and updates state.
// Depends on cfdo_pkg.
module cfdo_ctrl
    import cfdo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int PTR_W = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_flush,
    input  logic [CMD_W-1:0] i_command,
    input  logic [IDX_W-1:0] i_peek_index,
    input  logic [CNT_W-1:0] i_cap,
    input  logic             i_mode,
    output logic [PTR_W-1:0] o_waddr,
    output logic [PTR_W-1:0] o_raddr,
    output t_step_info       o_info
);

    localparam int AW = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;
    logic [AW-1:0]    peek_sum;
    logic             is_full;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
        logic [AW-1:0] nxt;
        nxt = AW'(p) + AW'(1);
        if (nxt >= AW'(cap)) begin
            return '0;
        end
        return nxt[PTR_W-1:0];
    endfunction

    always_comb begin
        n_wp          = r_wp;
        n_rp          = r_rp;
        n_count       = r_count;
        o_info.we     = 1'b0;
        o_info.re     = 1'b0;
        o_info.status = ST_OK;
        o_waddr       = r_wp;
        o_raddr       = r_rp;
        is_full       = (r_count >= i_cap);
        peek_sum      = AW'(r_rp) + AW'(i_peek_index);
        if (peek_sum >= AW'(i_cap)) begin
            peek_sum = peek_sum - AW'(i_cap);
        end
        case (t_cmd'(i_command))
            CMD_PUSH: begin
                if (is_full && !i_mode) begin
                    o_info.status = ST_FULL;
                end else begin
                    if (is_full) begin
                        n_rp = advance(r_rp, i_cap);
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    o_info.we = 1'b1;
                    n_wp      = advance(r_wp, i_cap);
                end
            end
            CMD_POP: begin
                if (r_count == '0) begin
                    o_info.status = ST_EMPTY;
                end else begin
                    o_info.re = 1'b1;
                    n_rp      = advance(r_rp, i_cap);
                    n_count   = r_count - CNT_W'(1);
                end
            end
            CMD_PEEK: begin
                if (r_count == '0) begin
                    o_info.status = ST_EMPTY;
                end else begin
                    o_info.re = 1'b1;
                end
            end
            CMD_PEEK_INDEX: begin
                if (CNT_W'(i_peek_index) >= r_count) begin
                    o_info.status = ST_RANGE;
                end else begin
                    o_info.re = 1'b1;
                    o_raddr   = peek_sum[PTR_W-1:0];
                end
            end
            CMD_CLEAR: begin
                n_wp    = '0;
                n_rp    = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
        o_info.fill_count = n_count;
        o_info.empty      = (n_count == '0);
        o_info.full       = (n_count >= i_cap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/cfdo_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the circular FIFO, bound to the top level.
// Depends on cfdo_pkg.
module cfdo_checker
    import cfdo_pkg::*;
#(
    parameter int ITEM_BITS = ITEM_BITS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [1:0]           o_status,
    input logic [ITEM_BITS-1:0] o_read_data,
    input logic [CNT_W-1:0]     o_fill_count,
    input logic                 o_empty_flag,
    input logic                 o_full_flag
);

    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_empty_flag == (o_fill_count == '0)))
        else $error("empty flag disagrees with fill count");

    a_not_empty_and_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_empty_flag && o_full_flag))
        else $error("empty and full together");

    a_drop_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> o_full_flag)
        else $error("drop status without full flag");

    a_no_data_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_read_data == '0))
        else $error("read data not zero on error status");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_read_data)))
        else $error("stalled result beat changed");

endmodule

bind circular_fifo_drop_or_overwrite cfdo_checker #(.ITEM_BITS(ITEM_BITS)) u_cfdo_checker (.*);

>>> bench/circular_fifo_drop_or_overwrite_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for circular_fifo_drop_or_overwrite: directed and random command
// streams are scored against an in-bench FIFO model, with registers set over APB.
// Depends on cfdo_pkg and the RTL top level.
module circular_fifo_drop_or_overwrite_tb;
    import cfdo_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int WORD_W     = ITEM_BITS_DEF;
    localparam int REPORT_MAX = 10;
    localparam int TIMEOUT_NS = 5_000_000;

    localparam logic [APB_AW-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_MODE     = {REG_MODE, 2'b00};
    localparam logic [CMD_W-1:0]  CMD_SPARE_LO  = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_SPARE_HI  = 3'd7;
    localparam logic              MODE_DROP      = 1'b0;
    localparam logic              MODE_OVERWRITE = 1'b1;

    typedef struct packed {
        t_status           status;
        logic [WORD_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              empty;
        logic              full;
    } t_fifo_result;

    logic                i_clk;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic [CMD_W-1:0]    i_command    = '0;
    logic [WORD_W-1:0]   i_push_data  = '0;
    logic [IDX_W-1:0]    i_peek_index = '0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic [1:0]          o_status;
    logic [WORD_W-1:0]   o_read_data;
    logic [CNT_W-1:0]    o_fill_count;
    logic                o_empty_flag;
    logic                o_full_flag;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [APB_AW-1:0]   paddr        = '0;
    logic [APB_DW-1:0]   pwdata       = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // FIFO model state
    logic [WORD_W-1:0] slot_mem [DEPTH];
    int unsigned       wr_ptr;
    int unsigned       rd_ptr;
    int unsigned       stored;
    logic [CNT_W-1:0]  capacity_reg;
    logic              overwrite_reg;

    t_fifo_result pending_results[$];
    int           mismatch_count = 0;
    bit           no_idle        = 1'b0;
    bit           filling        = 1'b1;

    circular_fifo_drop_or_overwrite uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_push_data  (i_push_data),
        .i_peek_index (i_peek_index),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_read_data  (o_read_data),
        .o_fill_count (o_fill_count),
        .o_empty_flag (o_empty_flag),
        .o_full_flag  (o_full_flag),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic int unsigned slots_in_use();
        if (capacity_reg == 0) return 1;
        if (capacity_reg > DEPTH) return DEPTH;
        return capacity_reg;
    endfunction

    function automatic int unsigned wrap_next(int unsigned p);
        return (p + 1 >= slots_in_use()) ? 0 : p + 1;
    endfunction

    function automatic void empty_model();
        wr_ptr = 0;
        rd_ptr = 0;
        stored = 0;
    endfunction

    // Applies one command to the model and returns the beat it should produce.
    function automatic t_fifo_result fifo_step(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] data,
                                               logic [IDX_W-1:0] idx);
        t_fifo_result r;
        int unsigned  cap;
        int unsigned  pos;
        cap      = slots_in_use();
        r.status = ST_OK;
        r.data   = '0;
        case (cmd)
            CMD_PUSH: begin
                if (stored >= cap && overwrite_reg == MODE_DROP) begin
                    r.status = ST_FULL;
                end else begin
                    if (stored >= cap) rd_ptr = wrap_next(rd_ptr);
                    else stored++;
                    slot_mem[wr_ptr] = data;
                    wr_ptr = wrap_next(wr_ptr);
                end
            end
            CMD_POP: begin
                if (stored == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = slot_mem[rd_ptr];
                    rd_ptr = wrap_next(rd_ptr);
                    stored--;
                end
            end
            CMD_PEEK: begin
                if (stored == 0) r.status = ST_EMPTY;
                else r.data = slot_mem[rd_ptr];
            end
            CMD_PEEK_INDEX: begin
                if (idx >= stored) begin
                    r.status = ST_RANGE;
                end else begin
                    pos = rd_ptr + idx;
                    if (pos >= cap) pos -= cap;
                    r.data = slot_mem[pos];
                end
            end
            CMD_CLEAR: empty_model();
            default: ;
        endcase
        r.count = CNT_W'(stored);
        r.empty = (stored == 0);
        r.full  = (stored >= cap);
        return r;
    endfunction

    function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endfunction

    // Result beats are scored in order against the model's predictions.
    always @(posedge i_clk) begin : score_beats
        t_fifo_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: beat with nothing expected, status %h data %h",
                             $time, o_status, o_read_data);
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("read_data", want.data, o_read_data);
                check_field("fill_count", want.count, o_fill_count);
                check_field("empty_flag", want.empty, o_empty_flag);
                check_field("full_flag", want.full, o_full_flag);
            end
        end
    end

    // Sink side: random back-pressure, off when no_idle is set.
    initial begin : drive_out_ready
        int unsigned stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall != 0 && !no_idle) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 5) == 0) stall = idle_gap();
            end
        end
    end

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] data,
                                input logic [IDX_W-1:0] idx);
        int unsigned gap;
        gap = no_idle ? 0 : idle_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_push_data  <= data;
        i_peek_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(fifo_step(cmd, data, idx));
    endtask

    task automatic push_word(input logic [WORD_W-1:0] data);
        send_command(CMD_PUSH, data, '0);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_CAPACITY) begin
            capacity_reg = value[CNT_W-1:0];
            empty_model();
        end else begin
            overwrite_reg = value[0];
        end
    endtask

    task automatic configure(input logic [CNT_W-1:0] capacity, input logic mode);
        wait_drained();
        write_register(ADDR_CAPACITY, APB_DW'(capacity));
        write_register(ADDR_MODE, APB_DW'(mode));
    endtask

    task automatic test_empty_fifo_commands();
        configure(9'd256, MODE_DROP);
        send_command(CMD_POP, '0, '0);
        send_command(CMD_PEEK, '0, '0);
        send_command(CMD_PEEK_INDEX, '0, '0);
        send_command(CMD_PEEK_INDEX, '0, 8'hFF);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            send_command(CMD_W'(c), '1, 8'hFF);
    endtask

    task automatic test_drop_when_full();
        configure(9'd3, MODE_DROP);
        push_word('0);
        push_word('1);
        push_word(32'hA5A5_A5A5);
        push_word(32'h5A5A_5A5A);
        send_command(CMD_PEEK_INDEX, '0, 8'd2);
        send_command(CMD_PEEK_INDEX, '0, 8'd3);
        send_command(CMD_POP, '0, '0);
        push_word(32'h1234_5678);
        send_command(CMD_PEEK_INDEX, '0, 8'd2);
        send_command(CMD_PEEK, '0, '0);
    endtask

    task automatic test_overwrite_when_full();
        configure(9'd2, MODE_OVERWRITE);
        push_word(32'h0000_0001);
        push_word(32'h8000_0000);
        push_word(32'hDEAD_BEEF);
        send_command(CMD_PEEK, '0, '0);
        send_command(CMD_POP, '0, '0);
        send_command(CMD_CLEAR, '0, '0);
        send_command(CMD_POP, '0, '0);
    endtask

    // Whole depth: fill past the top in drop mode, then switch to overwrite with contents kept.
    task automatic test_full_depth_fill();
        configure(9'd256, MODE_DROP);
        repeat (DEPTH + 2) push_word($urandom);
        send_command(CMD_PEEK_INDEX, '0, 8'hFF);
        send_command(CMD_PEEK, '0, '0);
        wait_drained();
        write_register(ADDR_MODE, APB_DW'(MODE_OVERWRITE));
        repeat (20) begin
            push_word($urandom);
            send_command(CMD_PEEK_INDEX, '0, 8'hFF);
        end
        repeat (30) send_command(CMD_POP, '0, '0);
        send_command(CMD_CLEAR, '0, '0);
    endtask

    task automatic test_random_traffic(input logic [CNT_W-1:0] capacity, input logic mode,
                                       input int unsigned beats, input bit steady);
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        int unsigned      roll;
        int unsigned      sel;
        configure(capacity, mode);
        no_idle = steady;
        filling = 1'b1;
        repeat (beats) begin
            if (stored == 0) filling = 1'b1;
            else if (stored >= slots_in_use() && $urandom_range(0, 3) == 0) filling = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 2) cmd = CMD_CLEAR;
            else if (roll < 4) cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            else if ($urandom_range(0, 99) < (filling ? 75 : 25)) cmd = CMD_PUSH;
            else begin
                sel = $urandom_range(0, 9);
                if (sel < 2) cmd = CMD_PEEK;
                else if (sel < 5) cmd = CMD_PEEK_INDEX;
                else cmd = CMD_POP;
            end
            if (stored != 0 && $urandom_range(0, 3) != 0) idx = IDX_W'($urandom_range(0, stored - 1));
            else idx = IDX_W'($urandom_range(0, 255));
            send_command(cmd, $urandom, idx);
            if ($urandom_range(0, 59) == 0) wait_drained();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        capacity_reg  = CAP_RESET;
        overwrite_reg = MODE_DROP;
        empty_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_fifo_commands();
        test_drop_when_full();
        test_overwrite_when_full();
        test_full_depth_fill();
        test_random_traffic(9'd1, MODE_OVERWRITE, 110, 1'b0);
        test_random_traffic(9'd0, MODE_DROP, 100, 1'b0);
        test_random_traffic(9'd5, MODE_DROP, 110, 1'b1);
        test_random_traffic(9'd5, MODE_OVERWRITE, 110, 1'b0);
        test_random_traffic(9'd511, MODE_OVERWRITE, 100, 1'b0);
        test_random_traffic(9'd16, MODE_OVERWRITE, 110, 1'b0);
        test_random_traffic(9'd2, MODE_DROP, 110, 1'b0);

        wait_drained();
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
rtl/cfdo_pkg.sv
rtl/cfdo_ctrl.sv
rtl/circular_fifo_drop_or_overwrite.sv
rtl/cfdo_checker.sv
bench/circular_fifo_drop_or_overwrite_tb.sv
